[rtl/core/u2c_pkg.sv]
// shared types, codes and decode functions of the utf-8 decoder
package u2c_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W = 21;
    localparam int MAX_RESULTS = 4;
    localparam int NRES_W = 3;

    localparam logic [CP_W-1:0] REPLACEMENT = 21'h00FFFD;

    // sequence length announced by a lead byte
    localparam logic [2:0] LEAD_BAD   = 3'd0;
    localparam logic [2:0] LEAD_ONE   = 3'd1;
    localparam logic [2:0] LEAD_TWO   = 3'd2;
    localparam logic [2:0] LEAD_THREE = 3'd3;
    localparam logic [2:0] LEAD_FOUR  = 3'd4;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        logic            end_of_string;
    } res_t;

    typedef struct packed {
        logic [NRES_W-1:0]           n_results;
        res_t [MAX_RESULTS-1:0]      results;
    } dec_out_t;

    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic [2:0]      adv;
    } dec_step_t;

    function automatic logic [2:0] lead_length(input logic [BYTE_W-1:0] b);
        logic [2:0] n;
        case (b) inside
            8'b0???????: n = LEAD_ONE;
            8'b110?????: n = LEAD_TWO;
            8'b1110????: n = LEAD_THREE;
            8'b11110???: n = LEAD_FOUR;
            default:     n = LEAD_BAD;
        endcase
        return n;
    endfunction

    // decode one code point from a four byte window, zero ends the data
    function automatic dec_step_t decode_at(input logic [BYTE_W-1:0] s0,
                                            input logic [BYTE_W-1:0] s1,
                                            input logic [BYTE_W-1:0] s2,
                                            input logic [BYTE_W-1:0] s3);
        dec_step_t  r;
        logic [2:0] n;
        n     = lead_length(s0);
        r.cp  = REPLACEMENT;
        r.adv = LEAD_ONE;
        case (n)
            LEAD_ONE: begin
                r.cp = {13'd0, s0};
            end
            LEAD_TWO: begin
                if (s1 != 8'd0) begin
                    r.cp  = {10'd0, s0[4:0], s1[5:0]};
                    r.adv = LEAD_TWO;
                end
            end
            LEAD_THREE: begin
                if (s1 != 8'd0 && s2 != 8'd0) begin
                    r.cp  = {5'd0, s0[3:0], s1[5:0], s2[5:0]};
                    r.adv = LEAD_THREE;
                end
            end
            LEAD_FOUR: begin
                if (s1 != 8'd0 && s2 != 8'd0 && s3 != 8'd0) begin
                    r.cp  = {s0[2:0], s1[5:0], s2[5:0], s3[5:0]};
                    r.adv = LEAD_FOUR;
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

endpackage

[rtl/core/u2c_decode.sv]
// sequence state and single pass decode of one registered byte
module u2c_decode (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       advance,
    input  logic [u2c_pkg::BYTE_W-1:0] byte_in,
    output u2c_pkg::dec_out_t          dec_out
);
    import u2c_pkg::*;

    logic [BYTE_W-1:0] held_reg [3];
    logic [BYTE_W-1:0] held_next [3];
    logic [1:0]        cnt_reg, cnt_next;
    logic [2:0]        seqlen_reg, seqlen_next;

    logic [2:0]        n_lead;
    logic              completes;
    logic [BYTE_W-1:0] m1, m2;
    dec_step_t         done_step, r0, r1, r2;
    res_t              end_res;

    assign n_lead    = lead_length(byte_in);
    assign completes = (({1'b0, cnt_reg} + 3'd1) == seqlen_reg);

    // held bytes beyond the fill count read as zero
    assign m1 = (cnt_reg >= 2'd2) ? held_reg[1] : 8'd0;
    assign m2 = (cnt_reg == 2'd3) ? held_reg[2] : 8'd0;

    assign r0 = decode_at(held_reg[0], m1, m2, 8'd0);
    assign r1 = decode_at(m1, m2, 8'd0, 8'd0);
    assign r2 = decode_at(m2, 8'd0, 8'd0, 8'd0);

    assign end_res = '{code_point: '0, end_of_string: 1'b1};

    always_comb begin
        case (seqlen_reg)
            LEAD_TWO:   done_step = decode_at(held_reg[0], byte_in, 8'd0, 8'd0);
            LEAD_THREE: done_step = decode_at(held_reg[0], held_reg[1], byte_in, 8'd0);
            default:    done_step = decode_at(held_reg[0], held_reg[1], held_reg[2], byte_in);
        endcase
    end

    always_comb begin
        held_next   = held_reg;
        cnt_next    = cnt_reg;
        seqlen_next = seqlen_reg;
        dec_out     = '0;
        if (seqlen_reg == LEAD_BAD) begin
            if (byte_in == 8'd0) begin
                dec_out.n_results  = 3'd1;
                dec_out.results[0] = end_res;
            end else if (n_lead == LEAD_ONE) begin
                dec_out.n_results  = 3'd1;
                dec_out.results[0] = '{code_point: {13'd0, byte_in}, end_of_string: 1'b0};
            end else if (n_lead == LEAD_BAD) begin
                dec_out.n_results  = 3'd1;
                dec_out.results[0] = '{code_point: REPLACEMENT, end_of_string: 1'b0};
            end else begin
                held_next[0] = byte_in;
                cnt_next     = 2'd1;
                seqlen_next  = n_lead;
            end
        end else if (byte_in != 8'd0) begin
            if (completes) begin
                dec_out.n_results  = 3'd1;
                dec_out.results[0] = '{code_point: done_step.cp, end_of_string: 1'b0};
                cnt_next           = 2'd0;
                seqlen_next        = LEAD_BAD;
            end else begin
                held_next[cnt_reg] = byte_in;
                cnt_next           = cnt_reg + 2'd1;
            end
        end else begin
            // end of string cuts a pending sequence: replay held bytes
            dec_out.results[0] = '{code_point: r0.cp, end_of_string: 1'b0};
            dec_out.results[1] = '{code_point: r1.cp, end_of_string: 1'b0};
            case (cnt_reg)
                2'd1: begin
                    dec_out.n_results  = 3'd2;
                    dec_out.results[1] = end_res;
                end
                2'd2: begin
                    dec_out.n_results  = 3'd3;
                    dec_out.results[2] = end_res;
                end
                default: begin
                    if (r1.adv == LEAD_ONE) begin
                        dec_out.n_results  = 3'd4;
                        dec_out.results[2] = '{code_point: r2.cp, end_of_string: 1'b0};
                        dec_out.results[3] = end_res;
                    end else begin
                        dec_out.n_results  = 3'd3;
                        dec_out.results[2] = end_res;
                    end
                end
            endcase
            cnt_next    = 2'd0;
            seqlen_next = LEAD_BAD;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            held_reg <= held_next;
        end
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            seqlen_reg <= LEAD_BAD;
        end else if (advance) begin
            cnt_reg    <= cnt_next;
            seqlen_reg <= seqlen_next;
        end
    end

endmodule

[rtl/core/u2c_result_queue.sv]
// result register holding the words of one byte and handing them out in order
module u2c_result_queue (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       load,
    input  u2c_pkg::dec_out_t          dec_out,
    output logic                       can_take,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [u2c_pkg::CP_W-1:0]   m_code_point,
    output logic                       m_end_of_string,
    output logic                       m_last_of_run
);
    import u2c_pkg::*;

    res_t              entries_reg [MAX_RESULTS];
    res_t              entries_next [MAX_RESULTS];
    logic [NRES_W-1:0] rem_reg, rem_next;
    logic [1:0]        ptr_reg, ptr_next;
    logic              pop;

    assign m_valid         = (rem_reg != '0);
    assign pop             = m_valid && m_ready;
    assign can_take        = (rem_reg == '0) || ((rem_reg == 3'd1) && m_ready);
    assign m_code_point    = entries_reg[ptr_reg].code_point;
    assign m_end_of_string = entries_reg[ptr_reg].end_of_string;
    assign m_last_of_run   = (rem_reg == 3'd1);

    always_comb begin
        entries_next = entries_reg;
        rem_next     = rem_reg;
        ptr_next     = ptr_reg;
        if (load && dec_out.n_results != '0) begin
            for (int i = 0; i < MAX_RESULTS; i++) begin
                entries_next[i] = dec_out.results[i];
            end
            rem_next = dec_out.n_results;
            ptr_next = 2'd0;
        end else if (pop) begin
            rem_next = rem_reg - 3'd1;
            ptr_next = ptr_reg + 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        entries_reg <= entries_next;
        if (!aresetn) begin
            rem_reg <= '0;
            ptr_reg <= 2'd0;
        end else begin
            rem_reg <= rem_next;
            ptr_reg <= ptr_next;
        end
    end

endmodule

[rtl/core/utf8_to_codepoint_decoder_top.sv]
// top level of the utf-8 to code point decoder
// Takes a zero-terminated utf-8 byte stream, one byte per word, and gives code points.
// Bytes below 0x80 pass straight through; a 2, 3 or 4 byte sequence gives its code
// point on the word carrying its final byte (continuation bytes count if nonzero,
// their 10 prefix is not checked); bad lead bytes give U+FFFD. A zero byte closes the
// string with an end_of_string word of code point 0; if a sequence is still open the
// lead gives U+FFFD first and the held bytes after it are decoded again, so up to four
// words come from that one byte. last_of_run marks the final word caused by each byte.
// Rate: one byte per cycle while the result register can take words; a byte passes
// the input register, then the result register, which holds all words of one byte
// and sends one per cycle as m_ready allows, so a cutting zero byte holds the input.
module utf8_to_codepoint_decoder_top (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [u2c_pkg::BYTE_W-1:0] s_byte_in,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [u2c_pkg::CP_W-1:0]   m_code_point,
    output logic                       m_end_of_string,
    output logic                       m_last_of_run
);
    import u2c_pkg::*;

    // input register
    logic              in_valid_reg, in_valid_next;
    logic [BYTE_W-1:0] in_byte_reg;

    logic              can_take;
    logic              advance;
    dec_out_t          dec_out;

    // the byte moves on into the decoder once the result register can take its words
    assign advance = in_valid_reg && can_take;
    assign s_ready = !in_valid_reg || advance;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_valid && s_ready) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_byte_in;
        end
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    // sequence state, decode of the registered byte
    u2c_decode u_decode (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .byte_in (in_byte_reg),
        .dec_out (dec_out)
    );

    // result register, one word out per cycle while m_ready is high
    u2c_result_queue u_queue (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (advance),
        .dec_out         (dec_out),
        .can_take        (can_take),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_point    (m_code_point),
        .m_end_of_string (m_end_of_string),
        .m_last_of_run   (m_last_of_run)
    );

endmodule

[sim/utf8_decode_checker.sv]
// checker that predicts code points from accepted bytes and compares every result word
`timescale 1ns / 100ps

module utf8_decode_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  logic [u2c_pkg::BYTE_W-1:0] s_byte_in,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  logic [u2c_pkg::CP_W-1:0]   m_code_point,
    input  logic                       m_end_of_string,
    input  logic                       m_last_of_run,
    output int                         mismatch_count,
    output int                         words_pending,
    output int                         words_checked,
    output int                         strings_closed
);

    typedef struct packed {
        logic [u2c_pkg::CP_W-1:0] cp;
        logic                     eos;
        logic                     last;
    } cp_word_t;

    cp_word_t cp_expect_q [$];

    // open sequence as the decoder should hold it
    logic [7:0] held_seq [0:2];
    int         held_n;
    logic [2:0] seq_n;

    function automatic logic [2:0] seq_span(input logic [7:0] b);
        if (!b[7]) return u2c_pkg::LEAD_ONE;
        if (b[7:5] == 3'b110) return u2c_pkg::LEAD_TWO;
        if (b[7:4] == 4'b1110) return u2c_pkg::LEAD_THREE;
        if (b[7:3] == 5'b11110) return u2c_pkg::LEAD_FOUR;
        return u2c_pkg::LEAD_BAD;
    endfunction

    // code point at w[0]; a zero byte inside the span makes it malformed
    function automatic logic [u2c_pkg::CP_W-1:0] window_cp(input logic [3:0][7:0] w,
                                                           output int span);
        logic [2:0]               n;
        logic [u2c_pkg::CP_W-1:0] acc;
        int                       i;
        n    = seq_span(w[0]);
        span = 1;
        acc  = '0;
        if (n == u2c_pkg::LEAD_BAD) return u2c_pkg::REPLACEMENT;
        if (n == u2c_pkg::LEAD_ONE) begin
            acc[7:0] = w[0];
            return acc;
        end
        case (n)
            u2c_pkg::LEAD_TWO:   acc = u2c_pkg::CP_W'(w[0] & 8'h1F);
            u2c_pkg::LEAD_THREE: acc = u2c_pkg::CP_W'(w[0] & 8'h0F);
            default:             acc = u2c_pkg::CP_W'(w[0] & 8'h07);
        endcase
        for (i = 1; i < int'(n); i++) begin
            if (w[i] == 8'd0) return u2c_pkg::REPLACEMENT;
            acc = (acc << 6) | u2c_pkg::CP_W'(w[i] & 8'h3F);
        end
        span = int'(n);
        return acc;
    endfunction

    function automatic cp_word_t word_of(input logic [u2c_pkg::CP_W-1:0] cp, input logic eos);
        cp_word_t w;
        w.cp   = cp;
        w.eos  = eos;
        w.last = 1'b0;
        return w;
    endfunction

    task automatic predict_byte(input logic [7:0] b);
        cp_word_t   run [0:3];
        logic [7:0] scratch [0:7];
        logic [2:0] n;
        int         k;
        int         pos;
        int         span;
        int         i;
        k = 0;
        for (i = 0; i < 8; i++) scratch[i] = 8'd0;
        if (seq_n == 3'd0) begin
            if (b == 8'd0) begin
                run[k] = word_of('0, 1'b1);
                k++;
            end else begin
                n = seq_span(b);
                if (n == u2c_pkg::LEAD_ONE) begin
                    run[k] = word_of({13'd0, b}, 1'b0);
                    k++;
                end else if (n == u2c_pkg::LEAD_BAD) begin
                    run[k] = word_of(u2c_pkg::REPLACEMENT, 1'b0);
                    k++;
                end else begin
                    held_seq[0] = b;
                    held_n      = 1;
                    seq_n       = n;
                    return;
                end
            end
        end else if (b != 8'd0) begin
            if (held_n + 1 >= int'(seq_n)) begin
                for (i = 0; i < held_n; i++) scratch[i] = held_seq[i];
                scratch[held_n] = b;
                run[k] = word_of(window_cp({scratch[3], scratch[2], scratch[1], scratch[0]},
                                           span), 1'b0);
                k++;
                held_n = 0;
                seq_n  = 3'd0;
            end else begin
                held_seq[held_n] = b;
                held_n++;
                return;
            end
        end else begin
            // string cut short: lead is malformed, bytes after it decoded again
            for (i = 0; i < held_n; i++) scratch[i] = held_seq[i];
            pos = 0;
            while (pos < held_n && scratch[pos] != 8'd0 && k < 3) begin
                run[k] = word_of(window_cp({scratch[pos+3], scratch[pos+2], scratch[pos+1],
                                            scratch[pos]}, span), 1'b0);
                k++;
                pos += span;
            end
            run[k] = word_of('0, 1'b1);
            k++;
            held_n = 0;
            seq_n  = 3'd0;
        end
        for (i = 0; i < k; i++) begin
            run[i].last = (i == k - 1);
            cp_expect_q.push_back(run[i]);
        end
    endtask

    always @(posedge aclk) begin
        cp_word_t want;
        if (!aresetn) begin
            cp_expect_q.delete();
            held_n        = 0;
            seq_n         = 3'd0;
            words_pending = 0;
        end else begin
            // result side first, so a word never meets an expectation made this edge
            if (m_valid && m_ready) begin
                words_checked++;
                if (m_end_of_string) strings_closed++;
                if (cp_expect_q.size() == 0) begin
                    $error("unexpected result word: code_point %h end_of_string %b",
                           m_code_point, m_end_of_string);
                    mismatch_count++;
                end else begin
                    want = cp_expect_q.pop_front();
                    if (m_code_point !== want.cp) begin
                        $error("code_point: expected %h, got %h", want.cp, m_code_point);
                        mismatch_count++;
                    end
                    if (m_end_of_string !== want.eos) begin
                        $error("end_of_string: expected %b, got %b", want.eos, m_end_of_string);
                        mismatch_count++;
                    end
                    if (m_last_of_run !== want.last) begin
                        $error("last_of_run: expected %b, got %b", want.last, m_last_of_run);
                        mismatch_count++;
                    end
                end
            end
            if (s_valid && s_ready) predict_byte(s_byte_in);
            words_pending = cp_expect_q.size();
        end
    end

endmodule

[sim/tb_utf8_to_codepoint_decoder_top.sv]
// testbench top: byte stimulus, receiver stalls, watchdog and verdict for the utf-8 decoder
`timescale 1ns / 100ps

module tb_utf8_to_codepoint_decoder_top;

    // cycles with no word moving on either side before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // minimum count of random bytes per idling phase, three phases
    localparam int PHASE_BYTES = 134;

    logic                       aclk;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic [u2c_pkg::BYTE_W-1:0] s_byte_in = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [u2c_pkg::CP_W-1:0]   m_code_point;
    logic                       m_end_of_string;
    logic                       m_last_of_run;

    int mismatch_count;
    int words_pending;
    int words_checked;
    int strings_closed;

    // handshake seen at the last rising edge, read back at the falling edge
    logic s_took = 1'b0;
    logic m_took = 1'b0;

    int s_gap_pct   = 0;
    int m_stall_pct = 0;
    int bytes_sent  = 0;

    // directed opening: end with nothing open, two ascii bytes, one sequence of each
    // length (the four byte one giving the largest code point through unchecked 0xff
    // continuations), a stray continuation, an invalid lead, an overlong pair giving
    // zero, then strings cut short by a zero byte that re-decode a complete pair,
    // an ascii byte, and nothing at all
    logic [7:0] opening_bytes [0:24] = '{
        8'h00, 8'h41, 8'h7F, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
        8'hF7, 8'hFF, 8'hFF, 8'hFF, 8'h80, 8'hFF, 8'hC0, 8'h80,
        8'hF0, 8'hC3, 8'hA9, 8'h00, 8'hE2, 8'h41, 8'h00, 8'hC3,
        8'h00
    };

    utf8_to_codepoint_decoder_top dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_point    (m_code_point),
        .m_end_of_string (m_end_of_string),
        .m_last_of_run   (m_last_of_run)
    );

    utf8_decode_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_byte_in       (s_byte_in),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_code_point    (m_code_point),
        .m_end_of_string (m_end_of_string),
        .m_last_of_run   (m_last_of_run),
        .mismatch_count  (mismatch_count),
        .words_pending   (words_pending),
        .words_checked   (words_checked),
        .strings_closed  (strings_closed)
    );

    // 20 ns clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        s_took <= aresetn && s_valid && s_ready;
        m_took <= aresetn && m_valid && m_ready;
    end

    // receiver: ready redrawn every cycle from the current stall rate
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= m_stall_pct);
    end

    // one byte word: optional idle gap, then valid held with the byte until taken
    task automatic push_byte(input logic [7:0] b);
        while ($urandom_range(0, 99) < s_gap_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_byte_in <= b;
        do @(negedge aclk); while (!s_took);
        bytes_sent++;
    endtask

    // continuation byte: mostly the proper 10 prefix, sometimes any nonzero byte
    function automatic logic [7:0] tail_byte();
        if ($urandom_range(0, 9) == 0) return 8'($urandom_range(1, 255));
        return 8'h80 | 8'($urandom_range(0, 63));
    endfunction

    // lead byte announcing n bytes, random payload bits
    function automatic logic [7:0] lead_byte(input int n);
        case (n)
            2:       return 8'hC0 | 8'($urandom_range(0, 31));
            3:       return 8'hE0 | 8'($urandom_range(0, 15));
            default: return 8'hF0 | 8'($urandom_range(0, 7));
        endcase
    endfunction

    // main stimulus
    initial begin
        int phase;
        int produced;
        int pick;
        int n;
        int c;
        int i;

        // reset held from the start, released on a falling edge
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (phase = 0; phase < 3; phase++) begin
            // sender idles 21 / receiver 45, then swapped, then no idling at all
            case (phase)
                0: begin
                    s_gap_pct   = 21;
                    m_stall_pct = 45;
                end
                1: begin
                    s_gap_pct   = 45;
                    m_stall_pct = 21;
                end
                default: begin
                    s_gap_pct   = 0;
                    m_stall_pct = 0;
                end
            endcase

            if (phase == 0) begin
                for (i = 0; i < 25; i++) push_byte(opening_bytes[i]);
            end

            produced = 0;
            while (produced < PHASE_BYTES) begin
                pick = $urandom_range(0, 99);
                if (pick < 38) begin
                    // plain ascii
                    push_byte(8'($urandom_range(1, 127)));
                    produced++;
                end else if (pick < 77) begin
                    // sequence of 2, 3 or 4 bytes with random content, mostly well formed
                    n = $urandom_range(2, 4);
                    push_byte(lead_byte(n));
                    for (i = 1; i < n; i++) push_byte(tail_byte());
                    produced += n;
                end else if (pick < 86) begin
                    // sequence cut short by the end of the string
                    n = $urandom_range(2, 4);
                    c = $urandom_range(0, n - 2);
                    push_byte(lead_byte(n));
                    for (i = 0; i < c; i++) begin
                        // the held bytes may themselves open sequences or be ascii
                        if ($urandom_range(0, 2) == 0) push_byte(8'($urandom_range(1, 255)));
                        else push_byte(tail_byte());
                    end
                    push_byte(8'h00);
                    produced += c + 2;
                end else if (pick < 92) begin
                    // end of string with nothing open
                    push_byte(8'h00);
                    produced++;
                end else begin
                    // noise: any nonzero byte, often a stray continuation or bad lead
                    if ($urandom_range(0, 1) == 0) push_byte(8'($urandom_range(128, 255)));
                    else push_byte(8'($urandom_range(1, 255)));
                    produced++;
                end
            end
        end

        // close the last string so every open sequence drains
        push_byte(8'h00);
        s_valid <= 1'b0;

        // drain, watchdog covers a result that never comes
        while (words_pending != 0) @(negedge aclk);
        // then wait on so any stray word is caught
        repeat (6) @(negedge aclk);

        $display("run covered %0d bytes over three idling phases, %0d result words checked",
                 bytes_sent, words_checked);
        $display("%0d strings closed, including sequences cut short by the end of string",
                 strings_closed);
        if (mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog: abandon the run when nothing moves on either channel for too long
    initial begin
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(negedge aclk);
            if (s_took || m_took) stuck = 0;
            else stuck++;
        end
        $error("no word moved for %0d cycles", STALL_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

[files.f]
rtl/core/u2c_pkg.sv
rtl/core/u2c_decode.sv
rtl/core/u2c_result_queue.sv
rtl/core/utf8_to_codepoint_decoder_top.sv
sim/utf8_decode_checker.sv
sim/tb_utf8_to_codepoint_decoder_top.sv
